// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lpfr_pkg.sv -----
package lpfr_pkg;

    // Built frame count and page number width.
    localparam int NUM_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    // Derived and fixed widths.
    localparam int SLOT_W  = $clog2(NUM_FRAMES);
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int CFG_W   = 4;
    localparam int FAULT_W = 32;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [SLOT_W-1:0]    rank_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [PAGE_BITS-1:0] page_t;

    // Outcome of one lookup: hit, eviction and the slot that takes the page.
    typedef struct packed {
        logic  hit;
        logic  evict;
        slot_t slot;
    } decision_t;

endpackage

// ----- design/lpfr_lookup.sv -----
module lpfr_lookup
(
    input  lpfr_pkg::page_t                            page_q,
    input  logic [lpfr_pkg::NUM_FRAMES-1:0]            valid_eff,
    input  lpfr_pkg::page_t [lpfr_pkg::NUM_FRAMES-1:0] pages,
    input  lpfr_pkg::rank_t [lpfr_pkg::NUM_FRAMES-1:0] rank_eff,
    input  lpfr_pkg::count_t                           filled_eff,
    input  lpfr_pkg::count_t                           frames_n,
    output lpfr_pkg::decision_t                        decision
);

    logic            match_found;
    lpfr_pkg::slot_t match_slot;
    logic            victim_any;
    lpfr_pkg::rank_t victim_rank;
    lpfr_pkg::slot_t victim_slot;
    logic            frames_full;

    // Parallel compare against every valid frame; lowest matching slot wins.
    always_comb
    begin
        match_found = 1'b0;
        match_slot  = '0;
        for (int k = 0; k < lpfr_pkg::NUM_FRAMES; k++)
        begin
            if (!match_found && valid_eff[k] && (pages[k] == page_q))
            begin
                match_found = 1'b1;
                match_slot  = lpfr_pkg::SLOT_W'(k);
            end
        end
    end

    // Least recently used frame among the valid frames below the frame limit.
    always_comb
    begin
        victim_any  = 1'b0;
        victim_rank = '0;
        victim_slot = '0;
        for (int k = 0; k < lpfr_pkg::NUM_FRAMES; k++)
        begin
            if ((lpfr_pkg::CNT_W'(k) < frames_n) && valid_eff[k] &&
                (!victim_any || (rank_eff[k] > victim_rank)))
            begin
                victim_any  = 1'b1;
                victim_rank = rank_eff[k];
                victim_slot = lpfr_pkg::SLOT_W'(k);
            end
        end
    end

    // A miss evicts once the frames in use are all full, else fills the next slot.
    assign frames_full = (filled_eff >= frames_n);

    always_comb
    begin
        decision.hit   = match_found;
        decision.evict = !match_found && frames_full;
        if (match_found)
        begin
            decision.slot = match_slot;
        end
        else if (frames_full)
        begin
            decision.slot = victim_slot;
        end
        else
        begin
            decision.slot = lpfr_pkg::SLOT_W'(filled_eff);
        end
    end

endmodule

// ----- design/lpfr_frame_store.sv -----
`include "assert_macros.svh"

module lpfr_frame_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                start_new_q,
    input  lpfr_pkg::page_t     page_q,
    input  lpfr_pkg::count_t    frames_n,
    output lpfr_pkg::decision_t decision,
    output lpfr_pkg::page_t     evicted_page
);

    lpfr_pkg::page_t [lpfr_pkg::NUM_FRAMES-1:0] page_mem_reg;
    logic [lpfr_pkg::NUM_FRAMES-1:0]            valid_reg;
    logic [lpfr_pkg::NUM_FRAMES-1:0]            valid_next;
    lpfr_pkg::rank_t [lpfr_pkg::NUM_FRAMES-1:0] rank_reg;
    lpfr_pkg::rank_t [lpfr_pkg::NUM_FRAMES-1:0] rank_next;
    lpfr_pkg::count_t                           filled_reg;
    lpfr_pkg::count_t                           filled_next;

    logic [lpfr_pkg::NUM_FRAMES-1:0]            valid_eff;
    lpfr_pkg::rank_t [lpfr_pkg::NUM_FRAMES-1:0] rank_eff;
    lpfr_pkg::count_t                           filled_eff;
    logic                                       fill;
    lpfr_pkg::rank_t                            touch_limit;
    logic [lpfr_pkg::NUM_FRAMES-1:0]            fill_mask;

    // A request with start_new set empties the frames before its own lookup.
    assign valid_eff  = start_new_q ? '0 : valid_reg;
    assign rank_eff   = start_new_q ? '0 : rank_reg;
    assign filled_eff = start_new_q ? '0 : filled_reg;

    lpfr_lookup u_lookup
    (
        .page_q     (page_q),
        .valid_eff  (valid_eff),
        .pages      (page_mem_reg),
        .rank_eff   (rank_eff),
        .filled_eff (filled_eff),
        .frames_n   (frames_n),
        .decision   (decision)
    );

    assign fill         = !decision.hit && !decision.evict;
    assign touch_limit  = rank_eff[decision.slot];
    assign evicted_page = decision.evict ? page_mem_reg[decision.slot] : '0;

    // Recency update: the touched slot becomes rank zero and younger frames age.
    // A fill ages every valid frame.
    always_comb
    begin
        for (int k = 0; k < lpfr_pkg::NUM_FRAMES; k++)
        begin
            if (lpfr_pkg::SLOT_W'(k) == decision.slot)
            begin
                rank_next[k] = '0;
            end
            else if (valid_eff[k] && (fill || (rank_eff[k] < touch_limit)))
            begin
                rank_next[k] = rank_eff[k] + 1'b1;
            end
            else
            begin
                rank_next[k] = rank_eff[k];
            end
        end
    end

    // Fill bookkeeping.
    always_comb
    begin
        valid_next = valid_eff;
        if (fill)
        begin
            valid_next[decision.slot] = 1'b1;
        end
        filled_next = filled_eff + lpfr_pkg::CNT_W'(fill);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rank_reg   <= '0;
            filled_reg <= '0;
        end
        else if (step)
        begin
            valid_reg  <= valid_next;
            rank_reg   <= rank_next;
            filled_reg <= filled_next;
        end
    end

    // Page numbers are written on every miss; entries are read only while valid.
    always_ff @(posedge clk)
    begin
        if (step && !decision.hit)
        begin
            page_mem_reg[decision.slot] <= page_q;
        end
    end

    // Frames fill in order, so the valid frames are exactly those below the count.
    always_comb
    begin
        for (int k = 0; k < lpfr_pkg::NUM_FRAMES; k++)
        begin
            fill_mask[k] = (lpfr_pkg::CNT_W'(k) < filled_reg);
        end
    end

    `ASSERT_CLK(a_valid_prefix, valid_reg == fill_mask, "valid frames are not a prefix of the fill count")
    `ASSERT_CLK(a_filled_range, filled_reg <= lpfr_pkg::CNT_W'(lpfr_pkg::NUM_FRAMES), "fill count exceeds the frame count")
    `ASSERT_CLK(a_hit_valid, !(step && decision.hit) || valid_eff[decision.slot], "hit reported on an empty frame")

endmodule

// ----- design/lru_page_frame_replacement.sv -----
// LRU page frame replacement over a fully associative set of frames. One page
// reference is taken per clock cycle: busy never rises, so start may stay high on
// every cycle. Each reference is registered on entry, looked up against all frames
// at once in the following cycle, and its result is registered and appears on the
// result ports with done high in the cycle after the lookup. For each result done
// stays high for one cycle only and the receiver cannot stall it, so results must
// be captured when they appear. The frame limit register is written through
// cfg_valid/cfg_ready (always ready); it should be changed only when no request is
// in flight, and a value of zero acts as one while values above the built frame
// count act as that count. There is no clearing pass after reset.
`include "assert_macros.svh"

module lru_page_frame_replacement
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         start_new,
    input  lpfr_pkg::page_t              page,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lpfr_pkg::CFG_W-1:0]   cfg_data,
    output logic                         done,
    output logic                         hit,
    output lpfr_pkg::slot_t              slot,
    output logic                         evicted_valid,
    output lpfr_pkg::page_t              evicted_page,
    output logic [lpfr_pkg::FAULT_W-1:0] fault_total
);

    logic [lpfr_pkg::CFG_W-1:0]   cfg_reg;
    logic                         req_valid_reg;
    logic                         req_start_new_reg;
    lpfr_pkg::page_t              req_page_reg;
    logic [lpfr_pkg::FAULT_W-1:0] fault_reg;
    logic [lpfr_pkg::FAULT_W-1:0] fault_base;
    logic [lpfr_pkg::FAULT_W-1:0] fault_next;
    logic                         done_reg;
    logic                         hit_reg;
    lpfr_pkg::slot_t              slot_reg;
    logic                         ev_valid_reg;
    lpfr_pkg::page_t              ev_page_reg;

    lpfr_pkg::count_t             frames_n;
    lpfr_pkg::decision_t          decision;
    lpfr_pkg::page_t              store_ev_page;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Frame limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lpfr_pkg::CFG_W'(lpfr_pkg::NUM_FRAMES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg <= cfg_data;
        end
    end

    // Clamp the limit into one to the built frame count.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            frames_n = lpfr_pkg::CNT_W'(1);
        end
        else if (cfg_reg > lpfr_pkg::CFG_W'(lpfr_pkg::NUM_FRAMES))
        begin
            frames_n = lpfr_pkg::CNT_W'(lpfr_pkg::NUM_FRAMES);
        end
        else
        begin
            frames_n = lpfr_pkg::CNT_W'(cfg_reg);
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_start_new_reg <= start_new;
            req_page_reg      <= page;
        end
    end

    lpfr_frame_store u_frame_store
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (req_valid_reg),
        .start_new_q  (req_start_new_reg),
        .page_q       (req_page_reg),
        .frames_n     (frames_n),
        .decision     (decision),
        .evicted_page (store_ev_page)
    );

    // Fault counter: cleared by a request with start_new set, saturates at all ones.
    always_comb
    begin
        fault_base = req_start_new_reg ? '0 : fault_reg;
        fault_next = fault_base;
        if (!decision.hit && (fault_base != '1))
        begin
            fault_next = fault_base + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
            if (req_valid_reg)
            begin
                fault_reg <= fault_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            hit_reg      <= decision.hit;
            slot_reg     <= decision.slot;
            ev_valid_reg <= decision.evict;
            ev_page_reg  <= store_ev_page;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_reg;

    `ASSERT_NEXT(a_result_follows, req_valid_reg, done_reg, "registered request produced no result")
    `ASSERT_CLK(a_evict_is_miss, !(done_reg && evicted_valid) || !hit, "eviction reported on a hit")
    `ASSERT_CLK(a_hit_no_page, !(done_reg && hit) || (evicted_page == '0), "hit carries an evicted page")
    `ASSERT_CLK(a_miss_counted, !(done_reg && !hit) || (fault_total != '0), "miss left the fault count at zero")

endmodule

// ----- test/lru_page_frame_replacement_checker.sv -----
`timescale 1ns / 100ps

module lru_page_frame_replacement_checker
    import lpfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               start_new,
    input  page_t              page,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               done,
    input  logic               hit,
    input  slot_t              slot,
    input  logic               evicted_valid,
    input  page_t              evicted_page,
    input  logic [FAULT_W-1:0] fault_total,
    output int unsigned        pending,
    output int unsigned        mismatches
);

    localparam int REPORT_LIMIT = 10;

    // One lookup outcome as it appears on the result ports.
    typedef struct packed {
        logic               hit;
        slot_t              slot;
        logic               evicted_valid;
        page_t              evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } lookup_result_t;

    // Shadow copy of the frame table and the frame limit register.
    logic [CFG_W-1:0]   frame_limit;
    page_t              resident_page [NUM_FRAMES];
    logic               resident      [NUM_FRAMES];
    int unsigned        age           [NUM_FRAMES];
    int unsigned        fill_level;
    logic [FAULT_W-1:0] fault_tally;
    int unsigned        mismatch_tally;

    // Lookups still waiting for their result, oldest first.
    lookup_result_t     expected_lookups [$];

    // Empties every frame and clears the fault count.
    function automatic void clear_frames();
        int k;
        for (k = 0; k < NUM_FRAMES; k++)
        begin
            resident_page[k] = '0;
            resident[k]      = 1'b0;
            age[k]           = 0;
        end
        fill_level  = 0;
        fault_tally = '0;
    endfunction

    // Makes slot s the most recent; resident frames younger than lim age by one.
    function automatic void promote(input int unsigned s, input int unsigned lim);
        int k;
        for (k = 0; k < NUM_FRAMES; k++)
        begin
            if (k != s && resident[k] && age[k] < lim)
                age[k]++;
        end
        age[s] = 0;
    endfunction

    // Applies one page reference to the shadow table and returns its outcome.
    function automatic lookup_result_t resolve_reference(input logic fresh, input page_t pg);
        lookup_result_t r;
        int unsigned    limit;
        int unsigned    oldest;
        int             k;
        logic           found;
        logic           any;
        if (frame_limit == 0)
            limit = 1;
        else if (frame_limit > NUM_FRAMES)
            limit = NUM_FRAMES;
        else
            limit = frame_limit;
        if (fresh)
            clear_frames();
        r     = '0;
        found = 1'b0;
        // The lookup covers every resident frame, also those above the limit.
        for (k = 0; k < NUM_FRAMES; k++)
        begin
            if (!found && resident[k] && resident_page[k] == pg)
            begin
                found  = 1'b1;
                r.slot = slot_t'(k);
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            promote(r.slot, age[r.slot]);
        end
        else
        begin
            if (fill_level < limit)
            begin
                // Frames fill in order from slot 0.
                r.slot                    = slot_t'(fill_level);
                resident[fill_level]      = 1'b1;
                resident_page[fill_level] = pg;
                fill_level++;
                promote(r.slot, NUM_FRAMES);
            end
            else
            begin
                // The victim is the least recent resident frame below the limit.
                any    = 1'b0;
                oldest = 0;
                for (k = 0; k < limit; k++)
                begin
                    if (resident[k] && (!any || age[k] > oldest))
                    begin
                        any    = 1'b1;
                        oldest = age[k];
                        r.slot = slot_t'(k);
                    end
                end
                r.evicted_valid       = 1'b1;
                r.evicted_page        = resident_page[r.slot];
                resident_page[r.slot] = pg;
                promote(r.slot, age[r.slot]);
            end
            // The fault count saturates at its maximum.
            if (fault_tally != '1)
                fault_tally++;
        end
        r.fault_total = fault_tally;
        return r;
    endfunction

    // Track register writes and requests, and compare each result with the oldest lookup.
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        lookup_result_t got;
        if (!rst_n)
        begin
            frame_limit = CFG_W'(NUM_FRAMES);
            clear_frames();
            expected_lookups.delete();
            mismatch_tally = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frame_limit = cfg_data;

            if (done)
            begin
                got.hit           = hit;
                got.slot          = slot;
                got.evicted_valid = evicted_valid;
                got.evicted_page  = evicted_page;
                got.fault_total   = fault_total;
                if (expected_lookups.size() == 0)
                begin
                    mismatch_tally++;
                    if (mismatch_tally <= REPORT_LIMIT)
                        $display("%0t: result with no lookup pending: hit=%0b slot=%0d ev=%0b/%h faults=%0d",
                                 $realtime, got.hit, got.slot, got.evicted_valid,
                                 got.evicted_page, got.fault_total);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot
                        || got.evicted_valid !== want.evicted_valid
                        || got.evicted_page !== want.evicted_page
                        || got.fault_total !== want.fault_total)
                    begin
                        mismatch_tally++;
                        if (mismatch_tally <= REPORT_LIMIT)
                            $display({"%0t: lookup mismatch: expected hit=%0b slot=%0d ev=%0b/%h ",
                                      "faults=%0d, got hit=%0b slot=%0d ev=%0b/%h faults=%0d"},
                                     $realtime, want.hit, want.slot, want.evicted_valid,
                                     want.evicted_page, want.fault_total, got.hit, got.slot,
                                     got.evicted_valid, got.evicted_page, got.fault_total);
                    end
                end
            end

            if (start && !busy)
                expected_lookups.push_back(resolve_reference(start_new, page));

            pending    <= expected_lookups.size();
            mismatches <= mismatch_tally;
        end
    end

endmodule

// ----- test/tb_lru_page_frame_replacement.sv -----
`timescale 1ns / 100ps

module tb_lru_page_frame_replacement;
    import lpfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 60;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               start_new;
    page_t              page;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               done;
    logic               hit;
    slot_t              slot;
    logic               evicted_valid;
    page_t              evicted_page;
    logic [FAULT_W-1:0] fault_total;

    int unsigned        pending;
    int unsigned        mismatches;
    int unsigned        quiet_cycles = 0;
    bit                 pacing;

    lru_page_frame_replacement dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_new     (start_new),
        .page          (page),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    lru_page_frame_replacement_checker lookup_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_new     (start_new),
        .page          (page),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_lru_page_frame_replacement: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Issues one page reference, sometimes after an idle burst, and waits until it is taken.
    task automatic issue_reference(input logic fresh, input page_t pg);
        if (pacing && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start     <= 1'b1;
        start_new <= fresh;
        page      <= pg;
        do @(posedge clk); while (busy);
    endtask

    // Stops issuing and waits until every request has returned its result.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_limit(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random phase: set the frame limit, then reference pages mostly from a small
    // working set so that hits, fills and evictions all occur.
    task automatic run_phase(input logic [CFG_W-1:0] limit_value, input bit paced,
                             input bit fresh_start, input bit mid_pause);
        page_t       pool [12];
        int unsigned usable;
        int unsigned pool_size;
        int          k;
        int unsigned dice;
        logic        fresh;
        page_t       pg;
        drain();
        write_frame_limit(limit_value);
        pacing = paced;
        if (limit_value == 0)
            usable = 1;
        else if (limit_value > NUM_FRAMES)
            usable = NUM_FRAMES;
        else
            usable = limit_value;
        pool_size = $urandom_range(1, usable + 3);
        for (k = 0; k < pool_size; k++)
            pool[k] = page_t'($urandom);
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            dice  = $urandom_range(0, 99);
            fresh = (k == 0 && fresh_start) || dice < 3;
            if (dice >= 3 && dice < 12)
                pg = page_t'($urandom);
            else
                pg = pool[$urandom_range(0, pool_size - 1)];
            issue_reference(fresh, pg);
            if (mid_pause && k == PHASE_ITEMS / 2)
                drain();
        end
    endtask

    initial
    begin
        start     <= 1'b0;
        start_new <= 1'b0;
        page      <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        pacing    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limit: fill all eight frames, hit once, then evict the least recent page.
        issue_reference(1'b1, 16'h0000);
        issue_reference(1'b0, 16'hFFFF);
        issue_reference(1'b0, 16'h0001);
        issue_reference(1'b0, 16'h0002);
        issue_reference(1'b0, 16'h0003);
        issue_reference(1'b0, 16'h0004);
        issue_reference(1'b0, 16'h0005);
        issue_reference(1'b0, 16'h0006);
        issue_reference(1'b0, 16'h0000);
        issue_reference(1'b0, 16'h0007);

        // Shrink the limit with all frames full: a miss evicts below the limit,
        // while a page resident above it still hits.
        drain();
        write_frame_limit(4'd3);
        issue_reference(1'b0, 16'h1234);
        issue_reference(1'b0, 16'h0004);

        // A limit of zero behaves as a single frame.
        drain();
        write_frame_limit(4'd0);
        issue_reference(1'b1, 16'hAAAA);
        issue_reference(1'b0, 16'h5555);
        issue_reference(1'b0, 16'h5555);

        // A limit above the built frame count behaves as the full count.
        drain();
        write_frame_limit(4'd15);
        issue_reference(1'b0, 16'hAAAA);
        issue_reference(1'b0, 16'h8000);
        issue_reference(1'b1, 16'h8000);

        // Random phases across several limits, some changed without emptying the frames.
        run_phase(4'd1, 1'b1, 1'b1, 1'b0);
        run_phase(4'd8, 1'b1, 1'b0, 1'b0);
        run_phase(4'd0, 1'b1, 1'b0, 1'b1);
        run_phase(4'd15, 1'b0, 1'b0, 1'b0);
        run_phase(4'd2, 1'b1, 1'b0, 1'b0);
        run_phase(4'd9, 1'b1, 1'b1, 1'b0);
        run_phase(CFG_W'($urandom_range(3, 7)), 1'b1, 1'b0, 1'b0);
        run_phase(4'd8, 1'b0, 1'b1, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_lru_page_frame_replacement: done, clean");
        else
            $display("tb_lru_page_frame_replacement: done, errors");
        $finish;
    end

endmodule

// ----- lru_page_frame_replacement.f -----
+incdir+design
design/lpfr_pkg.sv
design/lpfr_lookup.sv
design/lpfr_frame_store.sv
design/lru_page_frame_replacement.sv
test/lru_page_frame_replacement_checker.sv
test/tb_lru_page_frame_replacement.sv
